>>> rtl/wsts_pkg.sv
package wsts_pkg;

    // Field widths of the item channels.
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 10;
    localparam int WEIGHT_W = 32;
    localparam int SUM_BITS = 42;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_DRAW  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET_RD,
        S_UP,
        S_DRAW_L,
        S_DRAW_S,
        S_DONE
    } state_t;

endpackage

>>> rtl/wsts_if.sv
interface wsts_in_if;
    logic                          valid;
    logic                          ready;
    logic [wsts_pkg::OP_W-1:0]     operation;
    logic [wsts_pkg::SLOT_W-1:0]   slot;
    logic [wsts_pkg::WEIGHT_W-1:0] weight;
    logic [wsts_pkg::SUM_BITS-1:0] target;

    modport source (output valid, operation, slot, weight, target, input ready);
    modport sink (input valid, operation, slot, weight, target, output ready);
endinterface

interface wsts_out_if;
    logic                          valid;
    logic                          ready;
    logic [wsts_pkg::STATUS_W-1:0] status;
    logic [wsts_pkg::SLOT_W-1:0]   chosen_slot;
    logic [wsts_pkg::WEIGHT_W-1:0] chosen_weight;
    logic [wsts_pkg::SUM_BITS-1:0] total_weight;

    modport source (output valid, status, chosen_slot, chosen_weight, total_weight,
                    input ready);
    modport sink (input valid, status, chosen_slot, chosen_weight, total_weight,
                  output ready);
endinterface

>>> rtl/wsts_ram.sv
module wsts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/weighted_sum_tree_sampler.sv
// Set and clear: the slot's node is read and rewritten, then each ancestor in turn, and the
// result is loaded into the output register once it is free; the next item is then taken.
// Draw: the walk goes down from the root, with a left-sum step at each node and an
// own-weight step where it does not go left. One item is in flight at a time.
// After reset the block sweeps the tree memory to zero, one entry a cycle, and accepts
// no item until the sweep is done.
module weighted_sum_tree_sampler #(
    parameter int SLOTS       = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    wsts_in_if.sink    in_ch,
    wsts_out_if.source out_ch
);

    localparam int SUM_W = wsts_pkg::SUM_BITS;
    localparam int IDX_W = $clog2(SLOTS);
    // Width wide enough to compare a target against a self weight without loss.
    localparam int CMP_W = (WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W;

    // One memory entry holds everything a tree node needs, so a node is
    // one read and one write.
    typedef struct packed {
        logic [SUM_W-1:0]       left;
        logic [WEIGHT_BITS-1:0] own;
        logic [SUM_W-1:0]       right;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    wsts_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [WEIGHT_BITS-1:0] weight_reg, weight_next;
    logic [WEIGHT_BITS-1:0] own_reg, own_next;
    logic [SUM_W-1:0]       t_reg, t_next;
    logic [SUM_W-1:0]       diff_reg, diff_next;
    logic [SUM_W-1:0]       total_reg, total_next;

    wsts_pkg::status_t      res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_slot_reg, res_slot_next;
    logic [WEIGHT_BITS-1:0] res_weight_reg, res_weight_next;

    logic                          out_valid_reg, out_valid_next;
    wsts_pkg::status_t             out_status_reg, out_status_next;
    logic [wsts_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [wsts_pkg::WEIGHT_W-1:0] out_weight_reg, out_weight_next;
    logic [SUM_W-1:0]              out_total_reg, out_total_next;

    // Memory port signals.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    entry_t           rd_entry;

    // Decode of the incoming item.
    logic in_fire;
    logic in_is_write;
    logic in_slot_ok;
    logic in_set_go;
    logic in_draw_go;
    logic clear_last;

    // Walk helpers.
    logic [IDX_W-1:0] parent_idx;
    logic [IDX_W-1:0] grand_idx;
    logic [IDX_W:0]   left_child;
    logic [IDX_W:0]   right_child;
    logic             left_out;
    logic             right_out;
    logic             t_below_left;
    logic             t_below_own;
    logic             out_load;

    assign rd_entry = entry_t'(mem_rdata);

    wsts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_tree_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ch.ready = (state_reg == wsts_pkg::S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign in_is_write = (in_ch.operation == wsts_pkg::OP_SET) ||
                         (in_ch.operation == wsts_pkg::OP_CLEAR);
    assign in_slot_ok  = (int'(in_ch.slot) < SLOTS);
    assign in_set_go   = in_is_write && in_slot_ok;
    // A draw walks the tree only when the tree holds weight and the target
    // falls below the total; the other two cases answer at once.
    assign in_draw_go  = (in_ch.operation == wsts_pkg::OP_DRAW) &&
                         (total_reg != '0) && (in_ch.target < total_reg);

    assign clear_last  = (clr_cnt_reg == IDX_W'(SLOTS - 1));

    // Heap layout: parent of node i is (i - 1) / 2; children are 2i + 1 and 2i + 2.
    assign parent_idx  = (idx_reg - IDX_W'(1)) >> 1;
    assign grand_idx   = (parent_idx - IDX_W'(1)) >> 1;
    assign left_child  = {idx_reg, 1'b0} + (IDX_W + 1)'(1);
    assign right_child = {idx_reg, 1'b0} + (IDX_W + 1)'(2);
    assign left_out    = (int'(left_child) >= SLOTS);
    assign right_out   = (int'(right_child) >= SLOTS);

    assign t_below_left = (t_reg < rd_entry.left);
    assign t_below_own  = (CMP_W'(t_reg) < CMP_W'(own_reg));

    assign out_load = (state_reg == wsts_pkg::S_DONE) && (!out_valid_reg || out_ch.ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsts_pkg::S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = wsts_pkg::S_IDLE;
                end
            end
            wsts_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_set_go)
                    begin
                        state_next = wsts_pkg::S_SET_RD;
                    end
                    else if (in_draw_go)
                    begin
                        state_next = wsts_pkg::S_DRAW_L;
                    end
                    else
                    begin
                        state_next = wsts_pkg::S_DONE;
                    end
                end
            end
            wsts_pkg::S_SET_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = wsts_pkg::S_DONE;
                end
                else
                begin
                    state_next = wsts_pkg::S_UP;
                end
            end
            wsts_pkg::S_UP:
            begin
                if (parent_idx == '0)
                begin
                    state_next = wsts_pkg::S_DONE;
                end
            end
            wsts_pkg::S_DRAW_L:
            begin
                if (t_below_left)
                begin
                    if (left_out)
                    begin
                        state_next = wsts_pkg::S_DONE;
                    end
                end
                else
                begin
                    state_next = wsts_pkg::S_DRAW_S;
                end
            end
            wsts_pkg::S_DRAW_S:
            begin
                if (t_below_own || right_out)
                begin
                    state_next = wsts_pkg::S_DONE;
                end
                else
                begin
                    state_next = wsts_pkg::S_DRAW_L;
                end
            end
            wsts_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = wsts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wsts_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        idx_next        = idx_reg;
        weight_next     = weight_reg;
        own_next        = own_reg;
        t_next          = t_reg;
        diff_next       = diff_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_weight_next = res_weight_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_entry;
        mem_raddr       = '0;

        case (state_reg)
            wsts_pkg::S_CLEAR:
            begin
                // Reset sweep: write a zero node at every address.
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            wsts_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    res_status_next = wsts_pkg::ST_OK;
                    res_slot_next   = '0;
                    res_weight_next = '0;
                    t_next          = in_ch.target;
                    if (in_ch.operation == wsts_pkg::OP_SET)
                    begin
                        weight_next = WEIGHT_BITS'(in_ch.weight);
                    end
                    else
                    begin
                        weight_next = '0;
                    end
                    if (in_set_go)
                    begin
                        idx_next  = IDX_W'(in_ch.slot);
                        mem_raddr = IDX_W'(in_ch.slot);
                    end
                    else
                    begin
                        idx_next  = '0;
                        mem_raddr = '0;
                    end
                    if (in_ch.operation == wsts_pkg::OP_DRAW)
                    begin
                        if (total_reg == '0)
                        begin
                            res_status_next = wsts_pkg::ST_EMPTY;
                        end
                        else if (in_ch.target >= total_reg)
                        begin
                            res_status_next = wsts_pkg::ST_RANGE;
                        end
                    end
                end
            end
            wsts_pkg::S_SET_RD:
            begin
                // The slot's node is here: swap in the new weight and keep the
                // difference for the ancestors. The root total moves by the same
                // difference, modulo the sum width.
                diff_next      = SUM_W'(weight_reg) - SUM_W'(rd_entry.own);
                total_next     = total_reg + diff_next;
                mem_we         = 1'b1;
                mem_waddr      = idx_reg;
                mem_wdata      = rd_entry;
                mem_wdata.own  = weight_reg;
                mem_raddr      = parent_idx;
            end
            wsts_pkg::S_UP:
            begin
                // Parent node is here. An odd child is a left child.
                mem_we    = 1'b1;
                mem_waddr = parent_idx;
                mem_wdata = rd_entry;
                if (idx_reg[0])
                begin
                    mem_wdata.left = rd_entry.left + diff_reg;
                end
                else
                begin
                    mem_wdata.right = rd_entry.right + diff_reg;
                end
                // Fetch the next ancestor while this one is written back.
                mem_raddr = grand_idx;
                idx_next  = parent_idx;
            end
            wsts_pkg::S_DRAW_L:
            begin
                if (t_below_left)
                begin
                    if (left_out)
                    begin
                        res_status_next = wsts_pkg::ST_RANGE;
                    end
                    else
                    begin
                        idx_next  = IDX_W'(left_child);
                        mem_raddr = IDX_W'(left_child);
                    end
                end
                else
                begin
                    t_next   = t_reg - rd_entry.left;
                    own_next = rd_entry.own;
                end
            end
            wsts_pkg::S_DRAW_S:
            begin
                if (t_below_own)
                begin
                    res_slot_next   = idx_reg;
                    res_weight_next = own_reg;
                end
                else
                begin
                    // The remainder is at least the own weight here, so the
                    // subtraction is exact in the sum width.
                    t_next = t_reg - SUM_W'(own_reg);
                    if (right_out)
                    begin
                        res_status_next = wsts_pkg::ST_RANGE;
                    end
                    else
                    begin
                        idx_next  = IDX_W'(right_child);
                        mem_raddr = IDX_W'(right_child);
                    end
                end
            end
            wsts_pkg::S_DONE:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Output register: holds one finished result while the next item works.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_weight_next = out_weight_reg;
        out_total_next  = out_total_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_slot_next   = wsts_pkg::SLOT_W'(res_slot_reg);
            out_weight_next = wsts_pkg::WEIGHT_W'(res_weight_reg);
            out_total_next  = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsts_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        weight_reg     <= weight_next;
        own_reg        <= own_next;
        t_reg          <= t_next;
        diff_reg       <= diff_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_weight_reg <= res_weight_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_weight_reg <= out_weight_next;
        out_total_reg  <= out_total_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.chosen_slot   = out_slot_reg;
    assign out_ch.chosen_weight = out_weight_reg;
    assign out_ch.total_weight  = out_total_reg;

endmodule

>>> tb/sv/testbench.sv
module testbench;

    // The block is built at its default size. The checker keeps a tree of the same size.
    localparam int TREE_SLOTS = 1024;

    // Operation code 3 has no meaning. The block must answer it with status ok and the
    // current total, and it must leave the tree unchanged.
    localparam logic [wsts_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Items to send in the random part. Unused operation codes do not count.
    localparam int RANDOM_ITEMS = 1600;

    // Length of the one long stretch in which the output is held off. One item is in
    // flight at a time and one result waits in the output register, so the input stalls
    // during this stretch.
    localparam int HOLD_OFF_CYCLES = 400;

    // Cycles to let pass after the last result.
    localparam int SETTLE_CYCLES = 60;

    // Bound on the length of the run, in cycles. It covers the sweep after reset, the time
    // each item spends in the block, the sender gaps and the output stalls, with a wide margin.
    localparam int CYCLE_LIMIT = 400000;

    // One result as the block should produce it.
    typedef struct packed {
        logic [wsts_pkg::STATUS_W-1:0] status;
        logic [wsts_pkg::SLOT_W-1:0]   chosen_slot;
        logic [wsts_pkg::WEIGHT_W-1:0] chosen_weight;
        logic [wsts_pkg::SUM_BITS-1:0] total;
    } answer_t;

    // The ledger keeps its own copy of the sum tree in heap layout. Every node holds its
    // own weight and the sums of its left and right subtrees. When an item is accepted,
    // the ledger applies it to this tree and queues the result that the block owes for
    // it. Each result that comes out is checked against the oldest answer in the queue.
    class sum_tree_ledger;
        logic [wsts_pkg::SUM_BITS-1:0] left_sum [TREE_SLOTS];
        logic [wsts_pkg::WEIGHT_W-1:0] own_weight [TREE_SLOTS];
        logic [wsts_pkg::SUM_BITS-1:0] right_sum [TREE_SLOTS];
        answer_t                       owed[$];
        int                            mismatches;

        function new();
            foreach (own_weight[n])
            begin
                left_sum[n]   = '0;
                own_weight[n] = '0;
                right_sum[n]  = '0;
            end
            mismatches = 0;
        endfunction

        function logic [wsts_pkg::SUM_BITS-1:0] root_total();
            return left_sum[0] + wsts_pkg::SUM_BITS'(own_weight[0]) + right_sum[0];
        endfunction

        // Replace the weight of one node. The change is added, modulo 2^42, to the
        // matching subtree sum of every ancestor. The change can be negative.
        function void reweigh(logic [wsts_pkg::SLOT_W-1:0] slot,
                              logic [wsts_pkg::WEIGHT_W-1:0] w);
            logic [wsts_pkg::SUM_BITS-1:0] change;
            int unsigned                   node;
            int unsigned                   parent;
            change = wsts_pkg::SUM_BITS'(w) - wsts_pkg::SUM_BITS'(own_weight[slot]);
            own_weight[slot] = w;
            node = slot;
            while (node > 0)
            begin
                parent = (node - 1) / 2;
                if (node % 2 == 0)
                    right_sum[parent] = right_sum[parent] + change;
                else
                    left_sum[parent] = left_sum[parent] + change;
                node = parent;
            end
        endfunction

        // Walk down from the root. At each node, go left while the target is below the
        // left sum. Otherwise take away the left sum, and pick this node if what is left
        // is below its own weight. Otherwise take away that weight as well and go right.
        function answer_t draw_answer(logic [wsts_pkg::SUM_BITS-1:0] target);
            answer_t                       a;
            logic [wsts_pkg::SUM_BITS-1:0] total;
            logic [wsts_pkg::SUM_BITS-1:0] rest;
            int unsigned                   node;
            int unsigned                   next;
            bit                            done;
            a = '0;
            total = root_total();
            if (total == '0)
                a.status = wsts_pkg::ST_EMPTY;
            else if (target >= total)
                a.status = wsts_pkg::ST_RANGE;
            else
            begin
                node = 0;
                next = 0;
                rest = target;
                done = 1'b0;
                while (!done)
                begin
                    if (rest < left_sum[node])
                        next = 2 * node + 1;
                    else
                    begin
                        rest = rest - left_sum[node];
                        if (rest < wsts_pkg::SUM_BITS'(own_weight[node]))
                        begin
                            a.status        = wsts_pkg::ST_OK;
                            a.chosen_slot   = wsts_pkg::SLOT_W'(node);
                            a.chosen_weight = own_weight[node];
                            done            = 1'b1;
                        end
                        else
                        begin
                            rest = rest - wsts_pkg::SUM_BITS'(own_weight[node]);
                            next = 2 * node + 2;
                        end
                    end
                    // A walk can only leave the tree after the sums have wrapped.
                    if (!done)
                    begin
                        if (next >= TREE_SLOTS)
                        begin
                            a.status = wsts_pkg::ST_RANGE;
                            done     = 1'b1;
                        end
                        else
                            node = next;
                    end
                end
            end
            return a;
        endfunction

        function void note_item(logic [wsts_pkg::OP_W-1:0] op,
                                logic [wsts_pkg::SLOT_W-1:0] slot,
                                logic [wsts_pkg::WEIGHT_W-1:0] weight,
                                logic [wsts_pkg::SUM_BITS-1:0] target);
            answer_t a;
            a = '0;
            case (op)
                wsts_pkg::OP_SET:   reweigh(slot, weight);
                wsts_pkg::OP_CLEAR: reweigh(slot, '0);
                wsts_pkg::OP_DRAW:  a = draw_answer(target);
                default:            ;
            endcase
            a.total = root_total();
            owed.push_back(a);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [wsts_pkg::STATUS_W-1:0] status,
                                   logic [wsts_pkg::SLOT_W-1:0] slot,
                                   logic [wsts_pkg::WEIGHT_W-1:0] weight,
                                   logic [wsts_pkg::SUM_BITS-1:0] total);
            answer_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                $display({"%0t: result with nothing outstanding, expected none, ",
                          "actual %0d %0d 0x%0h 0x%0h"},
                         $time, status, slot, weight, total);
                return;
            end
            want = owed.pop_front();
            compare_field("status", 64'(want.status), 64'(status));
            compare_field("chosen_slot", 64'(want.chosen_slot), 64'(slot));
            compare_field("chosen_weight", 64'(want.chosen_weight), 64'(weight));
            compare_field("total_weight", 64'(want.total), 64'(total));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wsts_in_if  in_ch ();
    wsts_out_if out_ch ();

    weighted_sum_tree_sampler i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sum_tree_ledger ledger = new();

    // The stimulus process asks for the long hold-off by raising hold_asked. The receiver
    // raises hold_served when it starts the stretch and then counts it out on its own.
    int hold_asked = 0;
    int hold_served = 0;
    int cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset is held at the start and is never asserted again.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it. This task is called just
    // after a rising edge. The item counts as accepted at the first later edge at which
    // ready is high. The task returns in that same time step and leaves valid high, so
    // that a following item can go out back to back.
    task automatic offer_item(logic [wsts_pkg::OP_W-1:0] op,
                              logic [wsts_pkg::SLOT_W-1:0] slot,
                              logic [wsts_pkg::WEIGHT_W-1:0] weight,
                              logic [wsts_pkg::SUM_BITS-1:0] target);
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.slot      <= slot;
        in_ch.weight    <= weight;
        in_ch.target    <= target;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        ledger.note_item(op, slot, weight, target);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    function automatic logic [wsts_pkg::SUM_BITS-1:0] random_wide();
        return wsts_pkg::SUM_BITS'({$urandom(), $urandom()});
    endfunction

    // Pick a target for a draw that should find a slot. The ends of the range are
    // favored, because that is where an off-by-one error in a compare would show.
    function automatic logic [wsts_pkg::SUM_BITS-1:0] target_in_range();
        logic [wsts_pkg::SUM_BITS-1:0] total;
        logic [63:0]                   wide;
        total = ledger.root_total();
        wide  = {$urandom(), $urandom()};
        if (total == '0)
            return random_wide();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return total - 1'b1;
            default: return wsts_pkg::SUM_BITS'(wide % 64'(total));
        endcase
    endfunction

    // Build one random item. Most items are well formed: sets that fill the tree with
    // many different kinds of weight, and draws whose target lies below the total. The
    // rest are clears, draws whose target is out of range, and the unused operation
    // code. Fields that an operation ignores still carry random bits.
    task automatic pick_item(output logic [wsts_pkg::OP_W-1:0] op,
                             output logic [wsts_pkg::SLOT_W-1:0] slot,
                             output logic [wsts_pkg::WEIGHT_W-1:0] weight,
                             output logic [wsts_pkg::SUM_BITS-1:0] target);
        int unsigned roll;
        roll   = $urandom_range(0, 99);
        slot   = wsts_pkg::SLOT_W'($urandom());
        weight = $urandom();
        target = random_wide();
        if (roll < 35)
        begin
            op = wsts_pkg::OP_SET;
            case ($urandom_range(0, 9))
                0, 1:    weight = '1;
                2, 3:    weight = wsts_pkg::WEIGHT_W'($urandom_range(1, 16));
                4:       weight = '0;
                default: ;
            endcase
        end
        else if (roll < 47)
            op = wsts_pkg::OP_CLEAR;
        else if (roll < 90)
        begin
            op     = wsts_pkg::OP_DRAW;
            target = target_in_range();
        end
        else if (roll < 96)
        begin
            op = wsts_pkg::OP_DRAW;
            // The sum cannot wrap at this size, so the total plus a small offset still
            // fits in 42 bits.
            if ($urandom_range(0, 1) == 0)
                target = ledger.root_total() + wsts_pkg::SUM_BITS'($urandom_range(0, 3));
        end
        else
            op = OP_UNUSED;
    endtask

    // The receiver stalls in modes that change after stretches of random length. In one
    // mode it is always ready. In another it stalls at random. In the third it follows a
    // rotating 16-bit pattern. The long hold-off takes priority over all of them.
    initial
    begin
        int          mode;
        int          mode_left;
        int          hold_left;
        int          pat_index;
        logic [15:0] pattern;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        pat_index = 0;
        pattern   = 16'h1;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                ledger.check_result(out_ch.status, out_ch.chosen_slot,
                                    out_ch.chosen_weight, out_ch.total_weight);
            if (hold_left == 0 && hold_served < hold_asked)
            begin
                hold_left   = HOLD_OFF_CYCLES;
                hold_served = hold_served + 1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
                pattern   = 16'($urandom()) | 16'h1;
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= pattern[pat_index];
                endcase
                pat_index = (pat_index + 1) % 16;
            end
        end
    end

    // Stimulus. The directed part comes first and the random part after it.
    initial
    begin
        logic [wsts_pkg::OP_W-1:0]     op;
        logic [wsts_pkg::SLOT_W-1:0]   slot;
        logic [wsts_pkg::WEIGHT_W-1:0] weight;
        logic [wsts_pkg::SUM_BITS-1:0] target;
        int                            sent;
        int                            burst;

        in_ch.valid     = 1'b0;
        in_ch.operation = wsts_pkg::OP_SET;
        in_ch.slot      = '0;
        in_ch.weight    = '0;
        in_ch.target    = '0;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // On an empty tree: a draw, the unused code, and a clear that changes nothing.
        offer_item(wsts_pkg::OP_DRAW, '0, '0, '0);
        offer_item(OP_UNUSED, 10'h3FF, '1, '1);
        offer_item(wsts_pkg::OP_CLEAR, 10'd5, '0, '0);

        // Full weights at the root and at the deepest slot, then small weights on both
        // a left child and a right child deep in the tree.
        offer_item(wsts_pkg::OP_SET, 10'd0, 32'hFFFF_FFFF, '0);
        offer_item(wsts_pkg::OP_SET, 10'd1023, 32'hFFFF_FFFF, '0);
        offer_item(wsts_pkg::OP_SET, 10'd1022, 32'd1, '0);
        offer_item(wsts_pkg::OP_SET, 10'd511, 32'd7, '0);

        // Draws at both ends of the range, at the total itself, and at the largest
        // target the field can carry.
        offer_item(wsts_pkg::OP_DRAW, '0, '0, '0);
        offer_item(wsts_pkg::OP_DRAW, '0, '0, ledger.root_total() - 1'b1);
        offer_item(wsts_pkg::OP_DRAW, '0, '0, ledger.root_total());
        offer_item(wsts_pkg::OP_DRAW, '0, '0, '1);

        // Lower a weight that is already set, so that the change is negative. Then
        // zero the root by a set with weight zero and clear a slot twice.
        offer_item(wsts_pkg::OP_SET, 10'd1023, 32'd5, '0);
        offer_item(wsts_pkg::OP_DRAW, '0, '0, target_in_range());
        offer_item(wsts_pkg::OP_SET, 10'd0, 32'd0, '0);
        offer_item(wsts_pkg::OP_CLEAR, 10'd1022, '1, '1);
        offer_item(wsts_pkg::OP_CLEAR, 10'd1022, '0, '0);
        offer_item(OP_UNUSED, '0, '0, '0);
        offer_item(wsts_pkg::OP_DRAW, '0, '0, ledger.root_total() - 1'b1);
        offer_item(wsts_pkg::OP_SET, 10'd700, 32'h8000_0000, '0);
        offer_item(wsts_pkg::OP_DRAW, '0, '0, target_in_range());
        offer_item(wsts_pkg::OP_DRAW, '0, '0, target_in_range());
        offer_item(wsts_pkg::OP_DRAW, '0, '0, target_in_range());

        // Random part. Items go out in bursts of random length. A gap of random length
        // follows each burst, and about a quarter of the gaps are zero, so that bursts
        // also run back to back. About halfway through, the receiver is asked to hold
        // off while the sender goes on offering items.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                pick_item(op, slot, weight, target);
                offer_item(op, slot, weight, target);
                if (op != OP_UNUSED)
                    sent++;
            end
            if (sent >= RANDOM_ITEMS / 2 && hold_asked == 0)
                hold_asked <= 1;
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 30));
        end
        in_ch.valid <= 1'b0;

        // Wait for every result still owed, then give the block time to show any
        // result that it should not produce.
        while (ledger.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (ledger.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/wsts_pkg.sv
rtl/wsts_if.sv
rtl/wsts_ram.sv
rtl/weighted_sum_tree_sampler.sv
tb/sv/testbench.sv
